// ===== hdl/polygon_ray_nearest_hit_core_defines.svh =====
// ----------------------------------------------------------------------------
// polygon_ray_nearest_hit_core_defines.svh
// Assertion macros shared by the polygon ray hit core.
// ----------------------------------------------------------------------------
`ifndef POLYGON_RAY_NEAREST_HIT_CORE_DEFINES_SVH
`define POLYGON_RAY_NEAREST_HIT_CORE_DEFINES_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define PRNH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prnh: assertion failed");
// expression must never be true outside reset
`define PRNH_NEVER(lbl, expr) \
  `PRNH_ASSERT(lbl, !(expr))
`else
`define PRNH_ASSERT(lbl, prop)
`define PRNH_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/prnh_pkg.sv =====
// ----------------------------------------------------------------------------
// prnh_pkg
// Types and fixed widths for the polygon ray hit core.
// ----------------------------------------------------------------------------
`default_nettype none
package prnh_pkg;
  localparam int COORD_W  = 16;
  localparam int FRAC_W   = 8;
  localparam int HIT_W    = 24;
  localparam int COUNT_W  = 7;
  localparam int DIFF_W   = COORD_W + 1;       // coordinate difference
  localparam int CROSS_W  = 2 * COORD_W + 3;   // signed cross product
  localparam int MAG_W    = 2 * COORD_W + 2;   // cross product magnitude
  localparam int CHUNK_W  = COORD_W + 1;       // multiplier chunk
  localparam int MOP_W    = COORD_W + 3;       // multiplier operand
  localparam int ACC_W    = 72;
  localparam int PROD_W   = MAG_W + DIFF_W;    // un * |edge axis|
  localparam int NUM_W    = PROD_W + FRAC_W + 2;
  localparam int QUO_W    = COORD_W + 1 + FRAC_W;
  localparam int DIV_W    = MAG_W + 1;
  localparam int CTR_W    = 5;

  typedef enum logic [1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_REPLACE = 2'd1,
    FUNC_ERASE   = 2'd2,
    FUNC_CAST    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_ADD  = 2'd1,
    MAC_SUB  = 2'd2
  } mac_op_t;

  typedef struct packed {
    logic    en;
    mac_op_t op;
    logic [1:0] sh;   // product shift in chunks
  } mac_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/prnh_store.sv =====
// ----------------------------------------------------------------------------
// prnh_store
// Vertex memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module prnh_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire  [AW-1:0]          wr_addr,
  input  wire prnh_pkg::vertex_t wr_data,
  input  wire                    rd_en,
  input  wire  [AW-1:0]          rd_addr,
  output prnh_pkg::vertex_t      rd_data
);
  prnh_pkg::vertex_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/prnh_mac.sv =====
// ----------------------------------------------------------------------------
// prnh_mac
// Shared multiply-accumulate unit: signed multiply, chunk shift, load/add/sub.
// ----------------------------------------------------------------------------
`default_nettype none
module prnh_mac (
  input  wire                                   clk,
  input  wire prnh_pkg::mac_ctl_t               ctl,
  input  wire signed [prnh_pkg::MOP_W-1:0]      op_a,
  input  wire signed [prnh_pkg::MOP_W-1:0]      op_b,
  output logic signed [prnh_pkg::ACC_W-1:0]     acc
);
  logic signed [2*prnh_pkg::MOP_W-1:0] prod;
  logic signed [prnh_pkg::ACC_W-1:0]   prod_ext;
  logic signed [prnh_pkg::ACC_W-1:0]   term;

  // product, sign extended and placed at its chunk position
  always_comb begin
    prod     = op_a * op_b;
    prod_ext = prnh_pkg::ACC_W'(prod);
    case (ctl.sh)
      2'd0:    term = prod_ext;
      2'd1:    term = prod_ext <<< prnh_pkg::CHUNK_W;
      default: term = prod_ext <<< (2 * prnh_pkg::CHUNK_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      case (ctl.op)
        prnh_pkg::MAC_LOAD: acc <= term;
        prnh_pkg::MAC_ADD:  acc <= acc + term;
        prnh_pkg::MAC_SUB:  acc <= acc - term;
        default:            acc <= acc;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/polygon_ray_nearest_hit_core.sv =====
// ----------------------------------------------------------------------------
// polygon_ray_nearest_hit_core
// Polygon vertex store with nearest ray/edge hit search.
// ----------------------------------------------------------------------------
// Input channel (in_*): one item per command. in_tuser carries the function
// (append, replace last, erase last, cast); in_tdata carries the point and,
// for a cast, the through point. Output channel (out_*): exactly one item per
// input item, in order, with the hit point, vertex count and status.
// Append, replace and erase go straight to the done state, which loads the
// output register once it is free; the next item is then taken back in idle.
// A cast first fetches the first vertex, then works each edge in turn
// (memory read of its end vertex, six passes through the one shared
// multiplier for the cross products, hit check, advance), adding a compare
// when a candidate must be compared against the current best; a hit is then
// placed by two multiplier passes and a 25-step restoring divider per axis.
// One item is in work at a time; in_tready is high only when idle.
// A finished item sits in the output register, so the next item can be taken
// while the receiver stalls; it waits at its end until the register frees.
// Reset empties the store (count zero) and drops any pending output item.
// Vertex memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_ray_nearest_hit_core_defines.svh"
module polygon_ray_nearest_hit_core #(
  parameter int MAX_VERTICES = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // point_x, point_y, through_x, through_y
  input  wire  [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,  // hit_x, hit_y, vertex_count, 1 pad bit
  output logic [2:0]  out_tuser   // found, status
);
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CW    = prnh_pkg::COORD_W;
  localparam int DW    = prnh_pkg::DIFF_W;
  localparam int XW    = prnh_pkg::CROSS_W;
  localparam int MW    = prnh_pkg::MAG_W;
  localparam int QW    = prnh_pkg::QUO_W;
  localparam int VW    = prnh_pkg::DIV_W;
  localparam int HW2   = CW + prnh_pkg::FRAC_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST_RD, S_FIRST_W, S_END_RD, S_END_W, S_CROSS, S_CHECK,
    S_CMP, S_CMP_DEC, S_NEXT, S_PMUL, S_PDIV_INIT, S_PDIV, S_PSTORE, S_DONE
  } state_t;

  state_t                         state_r;
  logic [CNT_W-1:0]               count_r;
  logic [AW-1:0]                  idx_r;
  logic [prnh_pkg::CTR_W-1:0]     step_r;
  logic                           axis_r;
  logic signed [CW-1:0]           px_r, py_r;
  logic signed [DW-1:0]           rx_r, ry_r, ex_r, ey_r, wx_r, wy_r;
  prnh_pkg::vertex_t              cur_r, end_r;
  logic signed [XW-1:0]           d_r, tn_r;
  logic [MW-1:0]                  c_t_r, c_d_r, c_u_r;
  logic [MW-1:0]                  best_t_r, best_d_r, best_u_r;
  logic signed [CW-1:0]           best_sx_r, best_sy_r;
  logic signed [DW-1:0]           best_ex_r, best_ey_r;
  logic [VW-1:0]                  rem_r;
  logic [QW-1:0]                  nlo_r;
  logic                           found_r;
  logic [prnh_pkg::HIT_W-1:0]     hx_r, hy_r;
  prnh_pkg::status_t              status_r;
  logic                           out_valid_r;
  logic                           out_found_r;
  logic [prnh_pkg::HIT_W-1:0]     out_hx_r, out_hy_r;
  logic [prnh_pkg::COUNT_W-1:0]   out_count_r;
  prnh_pkg::status_t              out_status_r;

  // input unpacking
  prnh_pkg::func_t      in_func;
  logic signed [CW-1:0] in_px, in_py, in_tx, in_ty;
  logic                 in_acc;
  assign in_func = prnh_pkg::func_t'(in_tuser);
  assign in_px   = in_tdata[15:0];
  assign in_py   = in_tdata[31:16];
  assign in_tx   = in_tdata[47:32];
  assign in_ty   = in_tdata[63:48];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // store ports
  logic                full, empty;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [CNT_W-1:0]    count_m1, idx_ext, idx_p1;
  prnh_pkg::vertex_t   wr_data, rd_data;
  logic                last_edge;

  assign full      = (count_r == CNT_W'(MAX_VERTICES));
  assign empty     = (count_r == '0);
  assign count_m1  = count_r - CNT_W'(1);
  assign idx_ext   = CNT_W'(idx_r);
  assign idx_p1    = idx_ext + CNT_W'(1);
  assign last_edge = (idx_p1 == count_r);
  assign wr_en     = in_acc && (((in_func == prnh_pkg::FUNC_APPEND) && !full) ||
                     ((in_func == prnh_pkg::FUNC_REPLACE) && !empty));
  assign wr_addr   = (in_func == prnh_pkg::FUNC_APPEND) ? count_r[AW-1:0]
                                                        : count_m1[AW-1:0];
  assign wr_data.x = in_px;
  assign wr_data.y = in_py;
  assign rd_en     = (state_r == S_FIRST_RD) || (state_r == S_END_RD);
  assign rd_addr   = ((state_r == S_FIRST_RD) || last_edge) ? '0 : idx_p1[AW-1:0];

  prnh_store #(.DEPTH(MAX_VERTICES), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared multiplier control
  prnh_pkg::mac_ctl_t                 mac_ctl;
  logic signed [prnh_pkg::MOP_W-1:0]  op_a, op_b;
  logic signed [prnh_pkg::ACC_W-1:0]  acc;
  logic signed [DW-1:0]               e_axis;
  logic [DW-1:0]                      e_mag;

  function automatic logic signed [prnh_pkg::MOP_W-1:0] chunk(
    input logic [MW-1:0] v, input logic hi);
    logic [prnh_pkg::CHUNK_W-1:0] c;
    c = hi ? v[MW-1:prnh_pkg::CHUNK_W] : v[prnh_pkg::CHUNK_W-1:0];
    return $signed({{(prnh_pkg::MOP_W - prnh_pkg::CHUNK_W){1'b0}}, c});
  endfunction

  assign e_axis = axis_r ? best_ey_r : best_ex_r;
  assign e_mag  = e_axis[DW-1] ? DW'(-e_axis) : DW'(e_axis);

  always_comb begin
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    case (state_r)
      S_CROSS: begin
        mac_ctl.en = 1'b1;
        mac_ctl.op = step_r[0] ? prnh_pkg::MAC_SUB : prnh_pkg::MAC_LOAD;
        case (step_r[2:0])
          3'd0:    begin op_a = prnh_pkg::MOP_W'(rx_r); op_b = prnh_pkg::MOP_W'(ey_r); end
          3'd1:    begin op_a = prnh_pkg::MOP_W'(ry_r); op_b = prnh_pkg::MOP_W'(ex_r); end
          3'd2:    begin op_a = prnh_pkg::MOP_W'(wx_r); op_b = prnh_pkg::MOP_W'(ey_r); end
          3'd3:    begin op_a = prnh_pkg::MOP_W'(wy_r); op_b = prnh_pkg::MOP_W'(ex_r); end
          3'd4:    begin op_a = prnh_pkg::MOP_W'(wx_r); op_b = prnh_pkg::MOP_W'(ry_r); end
          default: begin op_a = prnh_pkg::MOP_W'(wy_r); op_b = prnh_pkg::MOP_W'(rx_r); end
        endcase
      end
      S_CMP: begin
        // cand_t * best_d - best_t * cand_d, one partial product a step
        mac_ctl.en = 1'b1;
        mac_ctl.op = step_r[2] ? prnh_pkg::MAC_SUB
                   : ((step_r[1:0] == 2'd0) ? prnh_pkg::MAC_LOAD : prnh_pkg::MAC_ADD);
        mac_ctl.sh = {1'b0, step_r[1]} + {1'b0, step_r[0]};
        op_a = step_r[2] ? chunk(best_t_r, step_r[1]) : chunk(c_t_r, step_r[1]);
        op_b = step_r[2] ? chunk(c_d_r, step_r[0]) : chunk(best_d_r, step_r[0]);
      end
      S_PMUL: begin
        mac_ctl.en = 1'b1;
        mac_ctl.op = step_r[0] ? prnh_pkg::MAC_ADD : prnh_pkg::MAC_LOAD;
        mac_ctl.sh = {1'b0, step_r[0]};
        op_a = chunk(best_u_r, step_r[0]);
        op_b = $signed({{(prnh_pkg::MOP_W - DW){1'b0}}, e_mag});
      end
      default: ;
    endcase
  end

  prnh_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // edge hit test after the cross products
  logic                 d_neg, hit_ok, cmp_le;
  logic signed [XW-1:0] un_raw, dn, tnn, unn;
  assign un_raw = acc[XW-1:0];
  assign d_neg  = d_r[XW-1];
  assign dn     = d_neg ? -d_r : d_r;
  assign tnn    = d_neg ? -tn_r : tn_r;
  assign unn    = d_neg ? -un_raw : un_raw;
  assign hit_ok = (d_r != '0) && !tnn[XW-1] && (tnn != '0) && !unn[XW-1] && (unn <= dn);
  assign cmp_le = acc[prnh_pkg::ACC_W-1] || (acc == '0);

  // divider step and hit placement
  logic [VW-1:0]           d2;
  logic [VW:0]             rem2;
  logic                    q_bit;
  logic [VW:0]             rem_sub;
  logic [prnh_pkg::NUM_W-1:0] num;
  logic signed [HW2-1:0]   base, off, hitv;
  assign d2      = {best_d_r, 1'b0};
  assign rem2    = {rem_r, nlo_r[QW-1]};
  assign q_bit   = (rem2 >= {1'b0, d2});
  assign rem_sub = q_bit ? (rem2 - {1'b0, d2}) : rem2;
  assign num     = (prnh_pkg::NUM_W'(acc[prnh_pkg::PROD_W-1:0]) << (prnh_pkg::FRAC_W + 1))
                 + prnh_pkg::NUM_W'(best_d_r);
  assign base    = HW2'(axis_r ? best_sy_r : best_sx_r) <<< prnh_pkg::FRAC_W;
  assign off     = $signed({{(HW2 - QW){1'b0}}, nlo_r});
  assign hitv    = e_axis[DW-1] ? (base - off) : (base + off);

  // output count at field width
  logic [CNT_W+prnh_pkg::COUNT_W-1:0] count_wide;
  assign count_wide = (CNT_W + prnh_pkg::COUNT_W)'(count_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      step_r      <= '0;
      axis_r      <= 1'b0;
    end else begin
      // a finished item reloads the register itself in S_DONE
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            found_r  <= 1'b0;
            hx_r     <= '0;
            hy_r     <= '0;
            status_r <= prnh_pkg::STAT_OK;
            state_r  <= S_DONE;
            case (in_func)
              prnh_pkg::FUNC_APPEND: begin
                if (full) status_r <= prnh_pkg::STAT_FULL;
                else      count_r  <= count_r + CNT_W'(1);
              end
              prnh_pkg::FUNC_REPLACE: begin
                if (empty) status_r <= prnh_pkg::STAT_EMPTY;
              end
              prnh_pkg::FUNC_ERASE: begin
                if (empty) status_r <= prnh_pkg::STAT_EMPTY;
                else       count_r  <= count_m1;
              end
              default: begin
                px_r  <= in_px;
                py_r  <= in_py;
                rx_r  <= DW'(in_tx) - DW'(in_px);
                ry_r  <= DW'(in_ty) - DW'(in_py);
                idx_r <= '0;
                if (!empty) state_r <= S_FIRST_RD;
              end
            endcase
          end
        end
        S_FIRST_RD: state_r <= S_FIRST_W;
        S_FIRST_W: begin
          cur_r   <= rd_data;
          state_r <= S_END_RD;
        end
        S_END_RD: state_r <= S_END_W;
        S_END_W: begin
          end_r   <= rd_data;
          ex_r    <= DW'(rd_data.x) - DW'(cur_r.x);
          ey_r    <= DW'(rd_data.y) - DW'(cur_r.y);
          wx_r    <= DW'(cur_r.x) - DW'(px_r);
          wy_r    <= DW'(cur_r.y) - DW'(py_r);
          step_r  <= '0;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          step_r <= step_r + 1'b1;
          if (step_r == prnh_pkg::CTR_W'(2)) d_r  <= acc[XW-1:0];
          if (step_r == prnh_pkg::CTR_W'(4)) tn_r <= acc[XW-1:0];
          if (step_r == prnh_pkg::CTR_W'(5)) state_r <= S_CHECK;
        end
        S_CHECK: begin
          state_r <= S_NEXT;
          if (hit_ok) begin
            c_t_r <= MW'(tnn);
            c_d_r <= MW'(dn);
            c_u_r <= MW'(unn);
            if (!found_r) begin
              found_r   <= 1'b1;
              best_t_r  <= MW'(tnn);
              best_d_r  <= MW'(dn);
              best_u_r  <= MW'(unn);
              best_sx_r <= cur_r.x;
              best_sy_r <= cur_r.y;
              best_ex_r <= ex_r;
              best_ey_r <= ey_r;
            end else begin
              step_r  <= '0;
              state_r <= S_CMP;
            end
          end
        end
        S_CMP: begin
          step_r <= step_r + 1'b1;
          if (step_r == prnh_pkg::CTR_W'(7)) state_r <= S_CMP_DEC;
        end
        S_CMP_DEC: begin
          // ties go to the later edge
          if (cmp_le) begin
            best_t_r  <= c_t_r;
            best_d_r  <= c_d_r;
            best_u_r  <= c_u_r;
            best_sx_r <= cur_r.x;
            best_sy_r <= cur_r.y;
            best_ex_r <= ex_r;
            best_ey_r <= ey_r;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          cur_r <= end_r;
          if (last_edge) begin
            axis_r  <= 1'b0;
            step_r  <= '0;
            state_r <= found_r ? S_PMUL : S_DONE;
          end else begin
            idx_r   <= idx_p1[AW-1:0];
            state_r <= S_END_RD;
          end
        end
        S_PMUL: begin
          step_r <= step_r + 1'b1;
          if (step_r[0]) state_r <= S_PDIV_INIT;
        end
        S_PDIV_INIT: begin
          rem_r   <= num[QW +: VW];
          nlo_r   <= num[QW-1:0];
          step_r  <= '0;
          state_r <= S_PDIV;
        end
        S_PDIV: begin
          rem_r  <= rem_sub[VW-1:0];
          nlo_r  <= {nlo_r[QW-2:0], q_bit};
          step_r <= step_r + 1'b1;
          if (step_r == prnh_pkg::CTR_W'(QW - 1)) state_r <= S_PSTORE;
        end
        S_PSTORE: begin
          if (!axis_r) begin
            hx_r    <= hitv[prnh_pkg::HIT_W-1:0];
            axis_r  <= 1'b1;
            step_r  <= '0;
            state_r <= S_PMUL;
          end else begin
            hy_r    <= hitv[prnh_pkg::HIT_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= found_r;
            out_hx_r     <= hx_r;
            out_hy_r     <= hy_r;
            out_count_r  <= count_wide[prnh_pkg::COUNT_W-1:0];
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_hy_r, out_hx_r};
  assign out_tuser  = {out_status_r, out_found_r};

  `PRNH_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_VERTICES))
  `PRNH_ASSERT(a_div_rem, (state_r == S_PDIV) |-> (rem_r < d2))
  `PRNH_ASSERT(a_count_busy, (state_r != S_IDLE) |=> $stable(count_r))
  `PRNH_NEVER(a_found_status, out_valid_r && out_found_r &&
              (out_status_r != prnh_pkg::STAT_OK))
endmodule
`default_nettype wire
